// ----- rtl/core/twss_pkg.sv -----
// twss_pkg: shared widths, payload structs, action codes and controller/datapath
// command and status structs for the time-weighted statistics sampler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package twss_pkg;

   localparam int VALUE_BITS  = 32;
   localparam int TIME_BITS   = 32;
   localparam int WORD_BITS   = 32;
   localparam int COUNT_BITS  = 16;
   localparam int SUM_BITS    = 48;
   localparam int ACC_BITS    = 64;
   localparam int PERIOD_BITS = 17;
   localparam int MUL_BITS    = VALUE_BITS + TIME_BITS + 1;
   localparam int WIDE_BITS   = ACC_BITS + 2;
   localparam int DIV_CNT_BITS = $clog2(ACC_BITS);

   typedef logic signed [VALUE_BITS-1:0]  value_type;
   typedef logic        [TIME_BITS-1:0]   time_type;
   typedef logic signed [WORD_BITS-1:0]   word_type;
   typedef logic        [COUNT_BITS-1:0]  count_type;
   typedef logic signed [SUM_BITS-1:0]    sum_type;
   typedef logic signed [SUM_BITS:0]      sum_wide_type;
   typedef logic signed [ACC_BITS-1:0]    acc_type;
   typedef logic        [ACC_BITS-1:0]    mag_type;
   typedef logic signed [MUL_BITS-1:0]    prod_type;
   typedef logic signed [WIDE_BITS-1:0]   wide_type;
   typedef logic signed [PERIOD_BITS-1:0] period_type;
   typedef logic        [DIV_CNT_BITS-1:0] div_cnt_type;

   localparam period_type PERIOD_RESET = period_type'(1000);

   localparam logic [1:0] ACT_UPDATE = 2'd0;
   localparam logic [1:0] ACT_SAMPLE = 2'd1;
   localparam logic [1:0] ACT_FLUSH  = 2'd2;

   typedef struct packed {
      logic [1:0]         action;
      logic [31:0]        time_now;
      logic signed [31:0] sample_value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] time_avg;
      logic [15:0]        event_count;
      logic signed [31:0] max_value;
      logic signed [31:0] min_value;
      logic signed [47:0] value_sum;
      logic [31:0]        report_time;
   } rsp_type;

   typedef struct packed {
      logic latch_item;
      logic mul;
      logic fold;
      logic div_start;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic report_needed;
      logic use_div;
      logic div_busy;
   } status_type;

endpackage

`default_nettype wire

// ----- rtl/core/time_weighted_stats_sampler.sv -----
// Time-weighted statistics sampler, top level: joins controller and datapath.
// Depends on twss_pkg, twss_ctrl, twss_dp (and twss_div below it).
//
// Usage:
//   req channel (valid/stall) carries timestamped value updates, sample ticks
//   and flush requests. rsp channel (valid/stall) carries one report for each
//   sample tick, for a flush past the held value's time or with none held, and for every value
//   update in log-everything mode. csr_write_en/csr_write_data write the signed
//   sample period; write it only while the block is idle.
// Sequence:
//   one item is worked on at a time. An item that reports nothing passes
//   through capture, multiply and fold. A report without division adds an
//   emit step that loads the output register. With a positive period and a
//   nonzero window the 64-step bit-serial divider runs between fold and emit.
// Reset:
//   synchronous; period returns to 1000 and all window state clears.
// Stall:
//   a waiting result sits in the output register while the next item is
//   taken; a new report waits in its last step until that register drains.
`timescale 1ns / 1ps
`default_nettype none

module time_weighted_stats_sampler (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire twss_pkg::req_type    req_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output twss_pkg::rsp_type         rsp_data,
   input  wire logic                 csr_write_en,
   input  wire twss_pkg::period_type csr_write_data
);

   twss_pkg::cmd_type    cmd;
   twss_pkg::status_type status;

   twss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .status    (status)
   );

   twss_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_data       (req_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .rsp_data       (rsp_data)
   );

endmodule

`default_nettype wire

// ----- rtl/core/twss_div.sv -----
// twss_div: restoring divider, one quotient bit per cycle, unsigned
// magnitude dividend by unsigned divisor. Depends on twss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twss_div (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire twss_pkg::mag_type  dividend,
   input  wire twss_pkg::time_type divisor,
   output logic                    busy,
   output twss_pkg::mag_type       quotient
);

   localparam twss_pkg::div_cnt_type LAST_STEP =
      twss_pkg::div_cnt_type'(twss_pkg::ACC_BITS - 1);

   logic                       busy_ff, busy_in;
   twss_pkg::div_cnt_type      count_ff, count_in;
   twss_pkg::mag_type          quot_ff, quot_in;
   twss_pkg::time_type         rem_ff, rem_in;
   twss_pkg::time_type         divisor_ff, divisor_in;
   logic [twss_pkg::TIME_BITS:0] trial;
   logic [twss_pkg::TIME_BITS:0] diff;

   always_comb begin
      trial      = {rem_ff, quot_ff[twss_pkg::ACC_BITS-1]};
      diff       = trial - {1'b0, divisor_ff};
      busy_in    = busy_ff;
      count_in   = count_ff;
      quot_in    = quot_ff;
      rem_in     = rem_ff;
      divisor_in = divisor_ff;
      if (start) begin
         busy_in    = 1'b1;
         count_in   = '0;
         quot_in    = dividend;
         rem_in     = '0;
         divisor_in = divisor;
      end else if (busy_ff) begin
         // dividend bits shift out of the top while quotient bits enter below
         if (trial >= {1'b0, divisor_ff}) begin
            rem_in  = diff[twss_pkg::TIME_BITS-1:0];
            quot_in = {quot_ff[twss_pkg::ACC_BITS-2:0], 1'b1};
         end else begin
            rem_in  = trial[twss_pkg::TIME_BITS-1:0];
            quot_in = {quot_ff[twss_pkg::ACC_BITS-2:0], 1'b0};
         end
         count_in = count_ff + 1'b1;
         if (count_ff == LAST_STEP) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      quot_ff    <= quot_in;
      rem_ff     <= rem_in;
      divisor_ff <= divisor_in;
   end

   assign busy     = busy_ff;
   assign quotient = quot_ff;

   a_start_sets_busy: assert property (@(posedge clock) disable iff (reset)
      start |=> busy_ff)
      else $error("divider not busy after start");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_last_step_ends: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && count_ff == LAST_STEP && !start) |=> !busy_ff)
      else $error("divider ran past its last step");

endmodule

`default_nettype wire

// ----- rtl/core/twss_dp.sv -----
// twss_dp: datapath of the sampler: item capture, fold of the held value into
// the window statistics, report assembly and the output register.
// Depends on twss_pkg and twss_div.
`timescale 1ns / 1ps
`default_nettype none

module twss_dp (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire twss_pkg::cmd_type    cmd,
   output twss_pkg::status_type      status,
   input  wire twss_pkg::req_type    req_data,
   input  wire logic                 csr_write_en,
   input  wire twss_pkg::period_type csr_write_data,
   output twss_pkg::rsp_type         rsp_data
);

   localparam twss_pkg::acc_type ACC_MAX =
      twss_pkg::acc_type'({1'b0, {(twss_pkg::ACC_BITS-1){1'b1}}});
   localparam twss_pkg::acc_type ACC_MIN =
      twss_pkg::acc_type'({1'b1, {(twss_pkg::ACC_BITS-1){1'b0}}});
   localparam twss_pkg::sum_type SUM_MAX =
      twss_pkg::sum_type'({1'b0, {(twss_pkg::SUM_BITS-1){1'b1}}});
   localparam twss_pkg::sum_type SUM_MIN =
      twss_pkg::sum_type'({1'b1, {(twss_pkg::SUM_BITS-1){1'b0}}});
   localparam twss_pkg::word_type WORD_MAX =
      twss_pkg::word_type'({1'b0, {(twss_pkg::WORD_BITS-1){1'b1}}});
   localparam twss_pkg::word_type WORD_MIN =
      twss_pkg::word_type'({1'b1, {(twss_pkg::WORD_BITS-1){1'b0}}});

   // captured item
   logic [1:0]            act_ff;
   twss_pkg::time_type    time_ff;
   twss_pkg::value_type   value_ff;
   twss_pkg::prod_type    prod_ff, prod_in;
   twss_pkg::rsp_type     rsp_ff, rsp_in;

   // window state
   twss_pkg::period_type  period_ff;
   logic                  have_last_ff, have_last_in;
   twss_pkg::time_type    last_time_ff, last_time_in;
   twss_pkg::value_type   last_value_ff, last_value_in;
   twss_pkg::time_type    window_start_ff, window_start_in;
   twss_pkg::count_type   count_ff, count_in;
   twss_pkg::sum_type     sum_ff, sum_in;
   twss_pkg::acc_type     weighted_ff, weighted_in;
   twss_pkg::value_type   max_ff, max_in;
   twss_pkg::value_type   min_ff, min_in;

   twss_pkg::time_type    dt;
   twss_pkg::time_type    elapsed;
   logic                  flush_ok;
   logic                  folds;
   logic                  log_mode;
   logic                  avg_mode;
   twss_pkg::wide_type    wsum;
   twss_pkg::sum_wide_type ssum;
   twss_pkg::mag_type     dividend;
   twss_pkg::mag_type     quotient;
   logic                  div_busy;
   twss_pkg::word_type    avg;
   twss_pkg::word_type    quot_word;

   assign dt       = time_ff - last_time_ff;
   assign elapsed  = time_ff - window_start_ff;
   assign log_mode = period_ff[twss_pkg::PERIOD_BITS-1];
   assign avg_mode = !log_mode && (period_ff != '0);
   assign flush_ok = !have_last_ff || (time_ff > last_time_ff);
   // the held value is folded only when the item's time differs from its time (for a flush, only when later)
   assign folds    = have_last_ff && (last_time_ff != time_ff) &&
                     ((act_ff == twss_pkg::ACT_UPDATE) || (act_ff == twss_pkg::ACT_SAMPLE) ||
                      ((act_ff == twss_pkg::ACT_FLUSH) && flush_ok));

   assign prod_in  = $signed(last_value_ff) * $signed({1'b0, dt});
   assign wsum     = twss_pkg::wide_type'(weighted_ff) + twss_pkg::wide_type'(prod_ff);
   assign ssum     = twss_pkg::sum_wide_type'(sum_ff) +
                     twss_pkg::sum_wide_type'(last_value_ff);

   assign status.report_needed =
      ((act_ff == twss_pkg::ACT_UPDATE) && log_mode) ||
      (act_ff == twss_pkg::ACT_SAMPLE) ||
      ((act_ff == twss_pkg::ACT_FLUSH) && flush_ok);
   assign status.use_div  = avg_mode && (elapsed != '0);
   assign status.div_busy = div_busy;

   always_comb begin
      dividend = weighted_ff;
      if (weighted_ff[twss_pkg::ACC_BITS-1]) begin
         dividend = ~dividend + 1'b1;
      end
   end

   twss_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (elapsed),
      .busy     (div_busy),
      .quotient (quotient)
   );

   // signed, saturated quotient from magnitude and the sign of the weighted sum
   always_comb begin
      if (!weighted_ff[twss_pkg::ACC_BITS-1]) begin
         if (|quotient[twss_pkg::ACC_BITS-1:twss_pkg::WORD_BITS-1]) begin
            quot_word = WORD_MAX;
         end else begin
            quot_word = twss_pkg::word_type'(quotient[twss_pkg::WORD_BITS-1:0]);
         end
      end else begin
         if ((|quotient[twss_pkg::ACC_BITS-1:twss_pkg::WORD_BITS]) ||
             (quotient[twss_pkg::WORD_BITS-1] && (|quotient[twss_pkg::WORD_BITS-2:0]))) begin
            quot_word = WORD_MIN;
         end else begin
            quot_word = -twss_pkg::word_type'(quotient[twss_pkg::WORD_BITS-1:0]);
         end
      end
   end

   always_comb begin
      if (log_mode) begin
         avg = twss_pkg::word_type'(last_value_ff);
      end else if (avg_mode) begin
         avg = (elapsed == '0) ? '0 : quot_word;
      end else if (!weighted_ff[twss_pkg::ACC_BITS-1] &&
                   (|weighted_ff[twss_pkg::ACC_BITS-2:twss_pkg::WORD_BITS-1])) begin
         avg = WORD_MAX;
      end else if (weighted_ff[twss_pkg::ACC_BITS-1] &&
                   !(&weighted_ff[twss_pkg::ACC_BITS-2:twss_pkg::WORD_BITS-1])) begin
         avg = WORD_MIN;
      end else begin
         avg = twss_pkg::word_type'(weighted_ff[twss_pkg::WORD_BITS-1:0]);
      end
   end

   always_comb begin
      rsp_in.time_avg    = avg;
      rsp_in.event_count = count_ff;
      rsp_in.report_time = 32'(time_ff);
      if (log_mode) begin
         rsp_in.max_value = twss_pkg::word_type'(last_value_ff);
         rsp_in.min_value = twss_pkg::word_type'(last_value_ff);
         rsp_in.value_sum = twss_pkg::sum_type'(last_value_ff);
      end else begin
         rsp_in.max_value = twss_pkg::word_type'(max_ff);
         rsp_in.min_value = twss_pkg::word_type'(min_ff);
         rsp_in.value_sum = sum_ff;
      end
   end

   always_comb begin
      have_last_in    = have_last_ff;
      last_time_in    = last_time_ff;
      last_value_in   = last_value_ff;
      window_start_in = window_start_ff;
      count_in        = count_ff;
      sum_in          = sum_ff;
      weighted_in     = weighted_ff;
      max_in          = max_ff;
      min_in          = min_ff;
      if (cmd.fold) begin
         if (folds) begin
            if (count_ff != '1) begin
               count_in = count_ff + 1'b1;
            end
            if (!wsum[twss_pkg::WIDE_BITS-1] &&
                (|wsum[twss_pkg::WIDE_BITS-2:twss_pkg::ACC_BITS-1])) begin
               weighted_in = ACC_MAX;
            end else if (wsum[twss_pkg::WIDE_BITS-1] &&
                         !(&wsum[twss_pkg::WIDE_BITS-2:twss_pkg::ACC_BITS-1])) begin
               weighted_in = ACC_MIN;
            end else begin
               weighted_in = wsum[twss_pkg::ACC_BITS-1:0];
            end
            if (ssum[twss_pkg::SUM_BITS] != ssum[twss_pkg::SUM_BITS-1]) begin
               sum_in = ssum[twss_pkg::SUM_BITS] ? SUM_MIN : SUM_MAX;
            end else begin
               sum_in = ssum[twss_pkg::SUM_BITS-1:0];
            end
            if (last_value_ff > max_ff) begin
               max_in = last_value_ff;
            end
            if (last_value_ff < min_ff) begin
               min_in = last_value_ff;
            end
         end
         if (act_ff == twss_pkg::ACT_UPDATE) begin
            have_last_in  = 1'b1;
            last_time_in  = time_ff;
            last_value_in = value_ff;
         end
      end
      // window restart after a report
      if (cmd.load_out) begin
         count_in        = '0;
         sum_in          = '0;
         weighted_in     = '0;
         max_in          = last_value_ff;
         min_in          = last_value_ff;
         have_last_in    = 1'b1;
         last_time_in    = time_ff;
         window_start_in = time_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff       <= twss_pkg::PERIOD_RESET;
         have_last_ff    <= 1'b0;
         last_time_ff    <= '0;
         last_value_ff   <= '0;
         window_start_ff <= '0;
         count_ff        <= '0;
         sum_ff          <= '0;
         weighted_ff     <= '0;
         max_ff          <= '0;
         min_ff          <= '0;
      end else begin
         if (csr_write_en) begin
            period_ff <= csr_write_data;
         end
         have_last_ff    <= have_last_in;
         last_time_ff    <= last_time_in;
         last_value_ff   <= last_value_in;
         window_start_ff <= window_start_in;
         count_ff        <= count_in;
         sum_ff          <= sum_in;
         weighted_ff     <= weighted_in;
         max_ff          <= max_in;
         min_ff          <= min_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_item) begin
         act_ff   <= req_data.action;
         time_ff  <= req_data.time_now[twss_pkg::TIME_BITS-1:0];
         value_ff <= req_data.sample_value[twss_pkg::VALUE_BITS-1:0];
      end
      if (cmd.mul) begin
         prod_ff <= prod_in;
      end
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_data = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/core/twss_ctrl.sv -----
// twss_ctrl: controller state machine of the sampler; sequences capture,
// multiply, fold, divide and report, and owns the result valid.
// Depends on twss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module twss_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output twss_pkg::cmd_type         cmd,
   input  wire twss_pkg::status_type status
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FOLD,
      ST_DSTART,
      ST_DWAIT,
      ST_EMIT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd.latch_item = (state_ff == ST_IDLE) && req_valid;
      cmd.mul        = (state_ff == ST_MUL);
      cmd.fold       = (state_ff == ST_FOLD);
      cmd.div_start  = (state_ff == ST_DSTART);
      cmd.load_out   = (state_ff == ST_EMIT) && slot_free;
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            if (!status.report_needed) begin
               state_in = ST_IDLE;
            end else if (status.use_div) begin
               state_in = ST_DSTART;
            end else begin
               state_in = ST_EMIT;
            end
         end
         ST_DSTART: begin
            state_in = ST_DWAIT;
         end
         ST_DWAIT: begin
            if (!status.div_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_out) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

   a_transfer_starts_work: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff == ST_MUL))
      else $error("accepted item not processed");

   a_wait_after_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DWAIT && $past(state_ff) != ST_DWAIT) |-> $past(state_ff) == ST_DSTART)
      else $error("divider wait without start");

   a_load_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> rsp_valid_ff)
      else $error("loaded result not presented");

endmodule

`default_nettype wire
